>>> design/weighted_hybrid_memory_replacement_core_defines.svh
// Assertion macros shared by the weighted replacement core.
// Both macros expect clk and rst_n in scope.
`ifndef WEIGHTED_HYBRID_MEMORY_REPLACEMENT_CORE_DEFINES_SVH
`define WEIGHTED_HYBRID_MEMORY_REPLACEMENT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WHR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("whr assertion failed");
`define WHR_NEVER(name, expr) \
    `WHR_ASSERT(name, !(expr))
`else
`define WHR_ASSERT(name, prop)
`define WHR_NEVER(name, expr)
`endif
`endif

>>> design/whr_pkg.sv
package whr_pkg;

    localparam int WEIGHT_W  = 4;
    localparam int WAY_W     = 4;
    localparam int SET_IN_W  = 10;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_WAYS  = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 4'd15;

    // reset values of the start-weight registers
    localparam logic [WEIGHT_W-1:0] START_RST_NVM_DIRTY  = 4'd0;
    localparam logic [WEIGHT_W-1:0] START_RST_DRAM_DIRTY = 4'd3;
    localparam logic [WEIGHT_W-1:0] START_RST_NVM_CLEAN  = 4'd5;
    localparam logic [WEIGHT_W-1:0] START_RST_DRAM_CLEAN = 4'd7;

    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_NVM_DIRTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_DRAM_DIRTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_NVM_CLEAN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DRAM_CLEAN = 2'd3;

    typedef struct packed {
        logic accept;   // latch the word and read its set row
        logic update;   // modify the row, write it back, register the result
        logic clear;    // write one reset row of the clearing pass
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } ctrl_stat_t;

endpackage

>>> design/whr_ctrl.sv
`include "weighted_hybrid_memory_replacement_core_defines.svh"

module whr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output whr_pkg::ctrl_cmd_t  cmd,
    input  whr_pkg::ctrl_stat_t stat
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    assign cmd.accept = accept;
    assign cmd.update = (state_reg == ST_UPD);
    assign cmd.clear  = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPD);
        end
    end

    `WHR_ASSERT(a_accept_to_upd, accept |=> (state_reg == ST_UPD))
    `WHR_ASSERT(a_upd_one_cycle, (state_reg == ST_UPD) |=> (state_reg == ST_IDLE) && done_reg)
    `WHR_ASSERT(a_done_after_upd, done_reg |-> $past(state_reg == ST_UPD))

endmodule

>>> design/whr_dp.sv
`include "weighted_hybrid_memory_replacement_core_defines.svh"

module whr_dp #(
    parameter int SETS = 1024,
    parameter int WAYS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  whr_pkg::ctrl_cmd_t                    cmd,
    output whr_pkg::ctrl_stat_t                   stat,
    input  logic                                  cfg_we,
    input  logic [whr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [whr_pkg::WEIGHT_W-1:0]          cfg_data,
    input  logic [whr_pkg::CMD_W-1:0]             command,
    input  logic [whr_pkg::SET_IN_W-1:0]          set_index,
    input  logic [whr_pkg::WAY_W-1:0]             way_index,
    input  logic                                  is_nvm,
    input  logic                                  is_dirty,
    input  logic                                  is_write,
    input  logic                                  hit,
    output logic [whr_pkg::WAY_W-1:0]             victim_way
);

    localparam int WW    = whr_pkg::WEIGHT_W;
    localparam int ROW_W = WAYS * WW;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int EXT_W = ((SET_W > whr_pkg::SET_IN_W) ? SET_W : whr_pkg::SET_IN_W) + 1;
    localparam int WIDX  = $clog2(WAYS);

    logic [ROW_W-1:0] mem [SETS];

    logic [WW-1:0] start_nvm_dirty_reg;
    logic [WW-1:0] start_dram_dirty_reg;
    logic [WW-1:0] start_nvm_clean_reg;
    logic [WW-1:0] start_dram_clean_reg;

    logic [SET_W-1:0] clr_cnt_reg;

    logic [ROW_W-1:0]               row_reg;
    logic [SET_W-1:0]               addr_reg;
    logic                           in_range_reg;
    logic [whr_pkg::CMD_W-1:0]      cmd_reg;
    logic [whr_pkg::WAY_W-1:0]      way_reg;
    logic                           nvm_reg;
    logic                           dirty_reg;
    logic                           write_reg;
    logic                           hit_reg;
    logic [whr_pkg::WAY_W-1:0]      victim_reg;

    logic [EXT_W-1:0]  set_ext;
    logic [SET_W-1:0]  rd_addr;
    logic              in_range;
    logic [WW-1:0]     wt [WAYS];
    logic [WW-1:0]     new_wt [WAYS];
    logic [ROW_W-1:0]  new_row;
    logic [ROW_W-1:0]  clear_row;
    logic [WW-1:0]     start_w;
    logic [WW-1:0]     old_w;
    logic              way_ok;
    logic              fill_en;
    logic              hit_en;
    logic              wr_en;
    logic [WW-1:0]     tw [whr_pkg::MAX_WAYS];
    logic [whr_pkg::WAY_W-1:0] ti [whr_pkg::MAX_WAYS];
    logic [whr_pkg::WAY_W-1:0] best_way;

    assign set_ext  = EXT_W'(set_index);
    assign rd_addr  = set_ext[SET_W-1:0];
    assign in_range = set_ext < EXT_W'(SETS);

    assign stat.clear_last = (clr_cnt_reg == SET_W'(SETS - 1));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_nvm_dirty_reg  <= whr_pkg::START_RST_NVM_DIRTY;
            start_dram_dirty_reg <= whr_pkg::START_RST_DRAM_DIRTY;
            start_nvm_clean_reg  <= whr_pkg::START_RST_NVM_CLEAN;
            start_dram_clean_reg <= whr_pkg::START_RST_DRAM_CLEAN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                whr_pkg::REG_START_NVM_DIRTY:  start_nvm_dirty_reg  <= cfg_data;
                whr_pkg::REG_START_DRAM_DIRTY: start_dram_dirty_reg <= cfg_data;
                whr_pkg::REG_START_NVM_CLEAN:  start_nvm_clean_reg  <= cfg_data;
                whr_pkg::REG_START_DRAM_CLEAN: start_dram_clean_reg <= cfg_data;
            endcase
        end
    end

    // clearing pass counter, one row per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear && !stat.clear_last)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg     <= rd_addr;
            in_range_reg <= in_range;
            cmd_reg      <= command;
            way_reg      <= way_index;
            nvm_reg      <= is_nvm;
            dirty_reg    <= is_dirty;
            write_reg    <= is_write;
            hit_reg      <= hit;
        end
    end

    // weight memory: one row per set
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= mem[rd_addr];
        end
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= clear_row;
        end
        else if (wr_en)
        begin
            mem[addr_reg] <= new_row;
        end
    end

    assign clear_row = {WAYS{whr_pkg::WEIGHT_TOP}};

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            wt[w] = row_reg[w*WW +: WW];
        end
    end

    always_comb
    begin
        priority if (nvm_reg)
        begin
            start_w = dirty_reg ? start_nvm_dirty_reg : start_nvm_clean_reg;
        end
        else
        begin
            start_w = dirty_reg ? start_dram_dirty_reg : start_dram_clean_reg;
        end
    end

    assign way_ok  = {1'b0, way_reg} < (whr_pkg::WAY_W + 1)'(WAYS);
    assign old_w   = wt[way_reg[WIDX-1:0]];
    assign fill_en = in_range_reg && way_ok && (cmd_reg == whr_pkg::CMD_FILL);
    assign hit_en  = in_range_reg && way_ok && (cmd_reg == whr_pkg::CMD_ACCESS)
                     && !write_reg && hit_reg;
    assign wr_en   = cmd.update && (fill_en || hit_en);

    // per-way update, all ways in parallel
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            new_wt[w] = wt[w];
            if (fill_en)
            begin
                if (whr_pkg::WAY_W'(w) == way_reg)
                begin
                    new_wt[w] = start_w;
                end
                else if (wt[w] >= start_w && wt[w] != whr_pkg::WEIGHT_TOP)
                begin
                    new_wt[w] = wt[w] + WW'(1);
                end
            end
            else if (hit_en)
            begin
                if (whr_pkg::WAY_W'(w) == way_reg)
                begin
                    new_wt[w] = (old_w != '0) ? old_w - WW'(1) : old_w;
                end
                else if (wt[w] < old_w && wt[w] != whr_pkg::WEIGHT_TOP)
                begin
                    new_wt[w] = wt[w] + WW'(1);
                end
            end
            new_row[w*WW +: WW] = new_wt[w];
        end
    end

    // max tree; the right side wins only when strictly greater, so ties keep the lower way
    always_comb
    begin
        for (int i = 0; i < whr_pkg::MAX_WAYS; i++)
        begin
            tw[i] = (i < WAYS) ? row_reg[(i % WAYS)*WW +: WW] : '0;
            ti[i] = whr_pkg::WAY_W'(i);
        end
        for (int lvl = 0; lvl < whr_pkg::WAY_W; lvl++)
        begin
            for (int i = 0; i < (whr_pkg::MAX_WAYS >> (lvl + 1)); i++)
            begin
                if (tw[2*i+1] > tw[2*i])
                begin
                    tw[i] = tw[2*i+1];
                    ti[i] = ti[2*i+1];
                end
                else
                begin
                    tw[i] = tw[2*i];
                    ti[i] = ti[2*i];
                end
            end
        end
        best_way = ti[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            victim_reg <= '0;
        end
        else if (cmd.update)
        begin
            victim_reg <= (in_range_reg && cmd_reg == whr_pkg::CMD_VICTIM) ? best_way : '0;
        end
    end

    assign victim_way = victim_reg;

    `WHR_NEVER(a_clear_vs_update, cmd.clear && (cmd.update || cmd.accept))
    `WHR_ASSERT(a_victim_in_range, {1'b0, victim_reg} < (whr_pkg::WAY_W + 1)'(WAYS))
    `WHR_ASSERT(a_victim_zero_else, (cmd.update && !(in_range_reg && cmd_reg == whr_pkg::CMD_VICTIM)) |=> (victim_reg == '0))

endmodule

>>> design/weighted_hybrid_memory_replacement_core.sv
// Weighted replacement policy for a set-associative DRAM/NVM cache.
// Command channel: a word is taken at a clock edge where start is high and
// busy is low; command, set_index, way_index, is_nvm, is_dirty, is_write and
// hit are sampled at that edge. Each word produces exactly one result: done
// pulses for one cycle with victim_way valid in that cycle (0 unless the
// command was find victim on a set in range). The receiver cannot stall, so
// the result must be taken in that cycle.
// Timing: the accepting edge loads the update state; done is registered from
// the update state. The set row is read from the weight memory at the
// accepting edge, then updated in parallel across all ways and written
// back in the update state. busy is high in the update state, so no new
// word is taken until that word's update is done.
// Configuration: cfg_we, cfg_index, cfg_data write one start-weight register
// per enabled edge, with no handshake; write them only while idle.
// Reset: after rst_n deasserts the block walks the weight memory one row per
// cycle setting every weight to 15; busy stays high until all rows are set.
module weighted_hybrid_memory_replacement_core #(
    parameter int SETS = 1024,
    parameter int WAYS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic                              cfg_we,
    input  logic [whr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [whr_pkg::WEIGHT_W-1:0]      cfg_data,
    input  logic [whr_pkg::CMD_W-1:0]         command,
    input  logic [whr_pkg::SET_IN_W-1:0]      set_index,
    input  logic [whr_pkg::WAY_W-1:0]         way_index,
    input  logic                              is_nvm,
    input  logic                              is_dirty,
    input  logic                              is_write,
    input  logic                              hit,
    output logic [whr_pkg::WAY_W-1:0]         victim_way
);

    whr_pkg::ctrl_cmd_t  cmd;
    whr_pkg::ctrl_stat_t stat;

    whr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    whr_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .set_index  (set_index),
        .way_index  (way_index),
        .is_nvm     (is_nvm),
        .is_dirty   (is_dirty),
        .is_write   (is_write),
        .hit        (hit),
        .victim_way (victim_way)
    );

endmodule

>>> sim/tb.sv
module tb;

    localparam logic [whr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_SETS = 1024;
    localparam int NUM_WAYS = 16;

    typedef struct packed {
        logic [whr_pkg::CMD_W-1:0]    command;
        logic [whr_pkg::SET_IN_W-1:0] set_index;
        logic [whr_pkg::WAY_W-1:0]    way_index;
        logic                         is_nvm;
        logic                         is_dirty;
        logic                         is_write;
        logic                         hit;
    } op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic cfg_we = 1'b0;
    logic [whr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [whr_pkg::WEIGHT_W-1:0] cfg_data = '0;
    logic [whr_pkg::CMD_W-1:0] command = '0;
    logic [whr_pkg::SET_IN_W-1:0] set_index = '0;
    logic [whr_pkg::WAY_W-1:0] way_index = '0;
    logic is_nvm = 1'b0;
    logic is_dirty = 1'b0;
    logic is_write = 1'b0;
    logic hit = 1'b0;
    logic [whr_pkg::WAY_W-1:0] victim_way;

    // predictor state
    logic [whr_pkg::WEIGHT_W-1:0] way_weight [0:NUM_SETS-1][0:NUM_WAYS-1];
    logic [whr_pkg::WEIGHT_W-1:0] start_weight [0:3];

    op_t pending_ops[$];
    logic [whr_pkg::WAY_W-1:0] victim_expect_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    weighted_hybrid_memory_replacement_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .command(command),
        .set_index(set_index),
        .way_index(way_index),
        .is_nvm(is_nvm),
        .is_dirty(is_dirty),
        .is_write(is_write),
        .hit(hit),
        .victim_way(victim_way)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // update one set row the way the replacement policy does and return the victim
    task automatic predict_word(input op_t op, output logic [whr_pkg::WAY_W-1:0] victim);
        logic [whr_pkg::WEIGHT_W-1:0] row [0:NUM_WAYS-1];
        logic [whr_pkg::WEIGHT_W-1:0] best;
        logic [whr_pkg::WEIGHT_W-1:0] init_w;
        logic [whr_pkg::WEIGHT_W-1:0] old;
        victim = '0;
        best = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            row[w] = way_weight[op.set_index][w];
        case (op.command)
            whr_pkg::CMD_VICTIM:
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (row[w] > best)
                    begin
                        best = row[w];
                        victim = whr_pkg::WAY_W'(w);
                    end
                end
            end
            whr_pkg::CMD_FILL:
            begin
                if (op.is_nvm)
                    init_w = op.is_dirty ? start_weight[whr_pkg::REG_START_NVM_DIRTY]
                                         : start_weight[whr_pkg::REG_START_NVM_CLEAN];
                else
                    init_w = op.is_dirty ? start_weight[whr_pkg::REG_START_DRAM_DIRTY]
                                         : start_weight[whr_pkg::REG_START_DRAM_CLEAN];
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (w != op.way_index && row[w] >= init_w
                        && row[w] != whr_pkg::WEIGHT_TOP)
                        row[w] = row[w] + 4'd1;
                end
                row[op.way_index] = init_w;
            end
            whr_pkg::CMD_ACCESS:
            begin
                if (!op.is_write && op.hit)
                begin
                    old = row[op.way_index];
                    if (old != 0)
                        row[op.way_index] = old - 4'd1;
                    // ways below the old weight age by one
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (w != op.way_index && row[w] < old
                            && row[w] != whr_pkg::WEIGHT_TOP)
                            row[w] = row[w] + 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int w = 0; w < NUM_WAYS; w++)
            way_weight[op.set_index][w] = row[w];
    endtask

    function automatic op_t mk_op(input logic [whr_pkg::CMD_W-1:0] cmd, input int set_i,
                                  input int way_i, input bit nvm, input bit dirty,
                                  input bit wr, input bit h);
        op_t op;
        op.command = cmd;
        op.set_index = 10'(set_i);
        op.way_index = 4'(way_i);
        op.is_nvm = nvm;
        op.is_dirty = dirty;
        op.is_write = wr;
        op.hit = h;
        return op;
    endfunction

    function automatic op_t rand_op();
        op_t op;
        int r;
        r = $urandom_range(99);
        if (r < 30)
            op.command = whr_pkg::CMD_VICTIM;
        else if (r < 60)
            op.command = whr_pkg::CMD_FILL;
        else if (r < 95)
            op.command = whr_pkg::CMD_ACCESS;
        else
            op.command = CMD_UNUSED;
        // keep most traffic on a few sets so their weights evolve
        if ($urandom_range(4) != 0)
        begin
            case ($urandom_range(3))
                0: op.set_index = 10'h000;
                1: op.set_index = 10'h3FF;
                2: op.set_index = 10'h2AA;
                default: op.set_index = 10'h155;
            endcase
        end
        else
            op.set_index = 10'($urandom);
        op.way_index = 4'($urandom);
        op.is_nvm = 1'($urandom);
        op.is_dirty = 1'($urandom);
        op.is_write = ($urandom_range(4) == 0);
        op.hit = ($urandom_range(5) != 0);
        return op;
    endfunction

    task automatic write_start_reg(input logic [whr_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [whr_pkg::WEIGHT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        start_weight[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_start_weights(input logic [whr_pkg::WEIGHT_W-1:0] nvm_dirty,
                                     input logic [whr_pkg::WEIGHT_W-1:0] dram_dirty,
                                     input logic [whr_pkg::WEIGHT_W-1:0] nvm_clean,
                                     input logic [whr_pkg::WEIGHT_W-1:0] dram_clean);
        write_start_reg(whr_pkg::REG_START_NVM_DIRTY, nvm_dirty);
        write_start_reg(whr_pkg::REG_START_DRAM_DIRTY, dram_dirty);
        write_start_reg(whr_pkg::REG_START_NVM_CLEAN, nvm_clean);
        write_start_reg(whr_pkg::REG_START_DRAM_CLEAN, dram_clean);
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || victim_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            pending_ops.push_back(rand_op());
    endtask

    // driver: hold a word while busy, then advance; bursts with random gaps
    always @(posedge clk)
    begin
        op_t op;
        logic [whr_pkg::WAY_W-1:0] v;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                op = pending_ops.pop_front();
                predict_word(op, v);
                victim_expect_q.push_back(v);
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops[0];
                    command <= op.command;
                    set_index <= op.set_index;
                    way_index <= op.way_index;
                    is_nvm <= op.is_nvm;
                    is_dirty <= op.is_dirty;
                    is_write <= op.is_write;
                    hit <= op.hit;
                    start <= 1'b1;
                    if (burst_left == 0)
                    begin
                        gap_left = $urandom_range(1, 6);
                        burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(0, 4);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: each done pulse carries one result word
    always @(posedge clk)
    begin
        logic [whr_pkg::WAY_W-1:0] exp_way;
        if (rst_n && done)
        begin
            if (victim_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected result victim_way=%0d", victim_way));
            else
            begin
                exp_way = victim_expect_q.pop_front();
                if (victim_way !== exp_way)
                    report_mismatch($sformatf("victim_way got %0d want %0d",
                                              victim_way, exp_way));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
                way_weight[s][w] = whr_pkg::WEIGHT_TOP;
        start_weight[whr_pkg::REG_START_NVM_DIRTY] = whr_pkg::START_RST_NVM_DIRTY;
        start_weight[whr_pkg::REG_START_DRAM_DIRTY] = whr_pkg::START_RST_DRAM_DIRTY;
        start_weight[whr_pkg::REG_START_NVM_CLEAN] = whr_pkg::START_RST_NVM_CLEAN;
        start_weight[whr_pkg::REG_START_DRAM_CLEAN] = whr_pkg::START_RST_DRAM_CLEAN;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on reset start weights
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 0, 9, 1, 1, 1, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 1023, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_FILL, 0, 15, 1, 1, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_FILL, 0, 0, 0, 1, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_FILL, 0, 7, 1, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_FILL, 0, 8, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 0, 15, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 0, 15, 0, 0, 0, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 0, 8, 0, 0, 0, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 0, 0, 0, 0, 1, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 0, 7, 1, 1, 1, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(CMD_UNUSED, 0, 5, 1, 1, 0, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_FILL, 1023, 15, 1, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 1023, 15, 1, 1, 0, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_ACCESS, 1023, 0, 0, 0, 0, 1));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 1023, 15, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(whr_pkg::CMD_VICTIM, 512, 3, 1, 0, 1, 0));
        push_random(90);
        drain();

        set_start_weights(4'd0, 4'd0, 4'd0, 4'd0);
        push_random(90);
        drain();

        set_start_weights(4'd15, 4'd15, 4'd15, 4'd15);
        push_random(90);
        drain();

        set_start_weights(4'd15, 4'd0, 4'd15, 4'd0);
        push_random(90);
        drain();

        set_start_weights(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
        push_random(90);
        drain();

        set_start_weights(whr_pkg::START_RST_NVM_DIRTY, whr_pkg::START_RST_DRAM_DIRTY,
                          whr_pkg::START_RST_NVM_CLEAN, whr_pkg::START_RST_DRAM_CLEAN);
        push_random(90);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/whr_pkg.sv
design/whr_ctrl.sv
design/whr_dp.sv
design/weighted_hybrid_memory_replacement_core.sv
sim/tb.sv
